@@ hw/rtl/ledser_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ledser_pkg
// Shared types and constants for the addressable LED bit serializer.
// ----------------------------------------------------------------------------
package ledser_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SHORT_W    = 10;
  localparam int unsigned LATCH_W    = 16;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned BITS_W     = 32;
  localparam int unsigned BIT_CNT_W  = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LATCH_TICKS = 2'd2;

  localparam logic [SHORT_W-1:0] SHORT_RESET = 10'd50;
  localparam logic [SHORT_W-1:0] LONG_RESET  = 10'd100;
  localparam logic [LATCH_W-1:0] LATCH_RESET = 16'd6500;

  // Index of the final bit in a 3-byte or 4-byte pixel.
  localparam logic [BIT_CNT_W-1:0] LAST_BIT_RGB  = 5'd23;
  localparam logic [BIT_CNT_W-1:0] LAST_BIT_RGBW = 5'd31;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_LATCH = 1'b1;

  // One classified job: a latch or a left-aligned pixel bit string.
  typedef struct packed {
    logic              latch;
    logic              four;
    logic [BITS_W-1:0] bits;
  } ledser_job_t;

  // Phase durations, already clamped to at least one tick.
  typedef struct packed {
    logic [DUR_W-1:0] short_dur;
    logic [DUR_W-1:0] long_dur;
    logic [DUR_W-1:0] latch_dur;
  } ledser_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HIGH,
    ST_LOW,
    ST_LATCH
  } ledser_state_t;

endpackage : ledser_pkg
`default_nettype wire

@@ hw/rtl/ledser_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ledser_front
// Accepts input transactions and classifies them into queue jobs.
// ----------------------------------------------------------------------------
module ledser_front (
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_op,
  input  wire logic [7:0]           in_red,
  input  wire logic [7:0]           in_green,
  input  wire logic [7:0]           in_blue,
  input  wire logic [7:0]           in_white,
  input  wire logic                 in_with_white,
  input  wire logic                 q_full,
  output logic                      q_push,
  output ledser_pkg::ledser_job_t   q_job
);

  always_comb begin
    in_stall   = q_full;
    q_push     = in_valid && !q_full;
    q_job.latch = (in_op == ledser_pkg::OP_LATCH);
    q_job.four  = in_with_white;
    // Bytes go out in order, MSB first: pack left-aligned.
    q_job.bits  = {in_red, in_green, in_blue, in_white};
  end

endmodule : ledser_front
`default_nettype wire

@@ hw/rtl/ledser_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ledser_queue
// Small register FIFO of jobs between the front and back halves.
// ----------------------------------------------------------------------------
module ledser_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire ledser_pkg::ledser_job_t push_job,
  output logic                         full,
  input  wire logic                    pop,
  output logic                         pop_valid,
  output ledser_pkg::ledser_job_t      pop_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  ledser_pkg::ledser_job_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             do_push, do_pop;

  always_comb begin
    full      = (count_r == CNT_FULL);
    pop_valid = (count_r != '0);
    pop_job   = mem_r[rd_ptr_r];
    do_push   = push && !full;
    do_pop    = pop && pop_valid;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule : ledser_queue
`default_nettype wire

@@ hw/rtl/ledser_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ledser_back
// Phase sequencer: expands one job into (level, duration, last) phases.
// ----------------------------------------------------------------------------
module ledser_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ledser_pkg::ledser_cfg_t     cfg,
  input  wire logic                        q_valid,
  input  wire ledser_pkg::ledser_job_t     q_job,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_level,
  output logic [ledser_pkg::DUR_W-1:0]     out_duration,
  output logic                             out_last
);

  ledser_pkg::ledser_state_t state_r, state_nxt;

  logic [ledser_pkg::BITS_W-1:0]    data_r,    data_nxt;
  logic [ledser_pkg::BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [ledser_pkg::BIT_CNT_W-1:0] last_bit_r, last_bit_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_level_r, out_level_nxt;
  logic [ledser_pkg::DUR_W-1:0] out_dur_r,   out_dur_nxt;
  logic                         out_last_r,  out_last_nxt;

  logic adv;
  logic cur_bit;

  always_comb begin
    adv     = !out_valid_r || !out_stall;
    cur_bit = data_r[ledser_pkg::BITS_W-1];

    state_nxt     = state_r;
    data_nxt      = data_r;
    bit_cnt_nxt   = bit_cnt_r;
    last_bit_nxt  = last_bit_r;
    out_valid_nxt = out_valid_r;
    out_level_nxt = out_level_r;
    out_dur_nxt   = out_dur_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;

    if (adv) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ledser_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          data_nxt     = q_job.bits;
          bit_cnt_nxt  = '0;
          last_bit_nxt = q_job.four ? ledser_pkg::LAST_BIT_RGBW
                                    : ledser_pkg::LAST_BIT_RGB;
          state_nxt    = q_job.latch ? ledser_pkg::ST_LATCH : ledser_pkg::ST_HIGH;
        end
      end
      ledser_pkg::ST_HIGH: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = 1'b1;
          out_dur_nxt   = cur_bit ? cfg.long_dur : cfg.short_dur;
          out_last_nxt  = 1'b0;
          state_nxt     = ledser_pkg::ST_LOW;
        end
      end
      ledser_pkg::ST_LOW: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = 1'b0;
          out_dur_nxt   = cur_bit ? cfg.short_dur : cfg.long_dur;
          out_last_nxt  = (bit_cnt_r == last_bit_r);
          data_nxt      = {data_r[ledser_pkg::BITS_W-2:0], 1'b0};
          bit_cnt_nxt   = bit_cnt_r + 1'b1;
          state_nxt     = (bit_cnt_r == last_bit_r) ? ledser_pkg::ST_IDLE
                                                    : ledser_pkg::ST_HIGH;
        end
      end
      ledser_pkg::ST_LATCH: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = 1'b0;
          out_dur_nxt   = cfg.latch_dur;
          out_last_nxt  = 1'b1;
          state_nxt     = ledser_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ledser_pkg::ST_IDLE;
      end
    endcase

    out_valid    = out_valid_r;
    out_level    = out_level_r;
    out_duration = out_dur_r;
    out_last     = out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ledser_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r      <= data_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    last_bit_r  <= last_bit_nxt;
    out_level_r <= out_level_nxt;
    out_dur_r   <= out_dur_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule : ledser_back
`default_nettype wire

@@ hw/rtl/addressable_led_bit_serializer_top.sv @@
// Path: an accepted transaction passes the queue, the sequencer's job load and the
// registered output stage before its first phase shows. Throughput: one phase per
// cycle from the sequencer while out_stall is low; each job also spends an idle
// state loading from the queue, so a new job starts only after the last is through.
// Reset: synchronous, active low; clears queue, sequencer and output valid and
// restores the durations to 50 / 100 / 6500 ticks.
`default_nettype none
// ----------------------------------------------------------------------------
// addressable_led_bit_serializer_top
// Line encoder for addressable LED strings: pixel and latch requests in,
// (level, duration, last) phases out.
// ----------------------------------------------------------------------------
module addressable_led_bit_serializer_top #(
  parameter int unsigned QUEUE_DEPTH = 2   // jobs buffered between front and back
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input transactions
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_op,
  input  wire logic [7:0]                          in_red,
  input  wire logic [7:0]                          in_green,
  input  wire logic [7:0]                          in_blue,
  input  wire logic [7:0]                          in_white,
  input  wire logic                                in_with_white,
  // result transactions
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_level,
  output logic [ledser_pkg::DUR_W-1:0]             out_duration,
  output logic                                     out_last,
  // register writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ledser_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ledser_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Timing registers. A write to an unknown index is dropped.
  logic [ledser_pkg::SHORT_W-1:0] short_ticks_r;
  logic [ledser_pkg::SHORT_W-1:0] long_ticks_r;
  logic [ledser_pkg::LATCH_W-1:0] latch_ticks_r;

  ledser_pkg::ledser_cfg_t cfg;
  ledser_pkg::ledser_job_t push_job, pop_job;
  logic q_full, q_push, q_pop, q_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_ticks_r <= ledser_pkg::SHORT_RESET;
      long_ticks_r  <= ledser_pkg::LONG_RESET;
      latch_ticks_r <= ledser_pkg::LATCH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ledser_pkg::CFG_SHORT_TICKS: short_ticks_r <= cfg_data[ledser_pkg::SHORT_W-1:0];
        ledser_pkg::CFG_LONG_TICKS:  long_ticks_r  <= cfg_data[ledser_pkg::SHORT_W-1:0];
        ledser_pkg::CFG_LATCH_TICKS: latch_ticks_r <= cfg_data[ledser_pkg::LATCH_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero duration counts as one tick so no phase is empty.
  always_comb begin
    cfg.short_dur = (short_ticks_r == '0) ? ledser_pkg::DUR_W'(1)
                                          : ledser_pkg::DUR_W'(short_ticks_r);
    cfg.long_dur  = (long_ticks_r == '0)  ? ledser_pkg::DUR_W'(1)
                                          : ledser_pkg::DUR_W'(long_ticks_r);
    cfg.latch_dur = (latch_ticks_r == '0) ? ledser_pkg::DUR_W'(1)
                                          : ledser_pkg::DUR_W'(latch_ticks_r);
  end

  // Front: take transactions while the queue has room.
  ledser_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .in_white      (in_white),
    .in_with_white (in_with_white),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  // Decouples intake from the phase sequencer.
  ledser_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (pop_job)
  );

  // Back: one phase per cycle, while the output is not stalled, into a registered output stage.
  ledser_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_job        (pop_job),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_level    (out_level),
    .out_duration (out_duration),
    .out_last     (out_last)
  );

endmodule : addressable_led_bit_serializer_top
`default_nettype wire

@@ test/ledser_checker.sv @@
// ----------------------------------------------------------------------------
// ledser_checker
// Watches the request, phase and register channels of the LED serializer,
// predicts the phase run of every accepted request and compares each phase
// taken from the block against it, field by field.
// ----------------------------------------------------------------------------
module ledser_checker
  import ledser_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic                  in_op,
  input  wire logic [7:0]            in_red,
  input  wire logic [7:0]            in_green,
  input  wire logic [7:0]            in_blue,
  input  wire logic [7:0]            in_white,
  input  wire logic                  in_with_white,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic                  out_level,
  input  wire logic [DUR_W-1:0]      out_duration,
  input  wire logic                  out_last,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         outstanding,
  output int                         fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic             level;
    logic [DUR_W-1:0] duration;
    logic             last;
  } phase_t;

  phase_t             phase_q[$];
  logic [SHORT_W-1:0] short_ticks_q;
  logic [SHORT_W-1:0] long_ticks_q;
  logic [LATCH_W-1:0] latch_ticks_q;
  int                 errors = 0;

  initial begin
    outstanding = 0;
    fail_count  = 0;
  end

  // a zero register still gives a one-tick phase
  function automatic logic [DUR_W-1:0] clamp_ticks(input logic [DUR_W-1:0] ticks);
    return (ticks == '0) ? DUR_W'(1) : ticks;
  endfunction

  task automatic expand_request(input logic op, input logic [7:0] red,
                                input logic [7:0] green, input logic [7:0] blue,
                                input logic [7:0] white, input logic with_white);
    logic [31:0]      bits;
    int               nbits;
    logic [DUR_W-1:0] short_dur;
    logic [DUR_W-1:0] long_dur;
    logic             one;
    short_dur = clamp_ticks(DUR_W'(short_ticks_q));
    long_dur  = clamp_ticks(DUR_W'(long_ticks_q));
    if (op == OP_LATCH) begin
      phase_q.push_back('{level: 1'b0, duration: clamp_ticks(DUR_W'(latch_ticks_q)),
                          last: 1'b1});
    end else begin
      bits  = {red, green, blue, white};
      nbits = with_white ? 32 : 24;
      for (int i = 0; i < nbits; i++) begin
        one = bits[31-i];
        phase_q.push_back('{level: 1'b1, duration: one ? long_dur : short_dur,
                            last: 1'b0});
        phase_q.push_back('{level: 1'b0, duration: one ? short_dur : long_dur,
                            last: (i == nbits - 1)});
      end
    end
  endtask

  task automatic report(input string field, input int unsigned exp_v,
                        input int unsigned act_v);
    if (errors < MAX_REPORTS)
      $error("%s: expected %0d, got %0d", field, exp_v, act_v);
    errors++;
  endtask

  always @(posedge clk) begin
    phase_t exp_ph;
    if (!rst_n) begin
      short_ticks_q = SHORT_RESET;
      long_ticks_q  = LONG_RESET;
      latch_ticks_q = LATCH_RESET;
      phase_q.delete();
    end else begin
      // results first: a phase can never come out on the edge its request goes in
      if (out_valid && !out_stall) begin
        if (phase_q.size() == 0) begin
          if (errors < MAX_REPORTS)
            $error("unexpected phase: level %0b duration %0d last %0b",
                   out_level, out_duration, out_last);
          errors++;
        end else begin
          exp_ph = phase_q.pop_front();
          if (out_level !== exp_ph.level)
            report("level", exp_ph.level, out_level);
          if (out_duration !== exp_ph.duration)
            report("duration", exp_ph.duration, out_duration);
          if (out_last !== exp_ph.last)
            report("last", exp_ph.last, out_last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SHORT_TICKS: short_ticks_q = cfg_data[SHORT_W-1:0];
          CFG_LONG_TICKS:  long_ticks_q  = cfg_data[SHORT_W-1:0];
          CFG_LATCH_TICKS: latch_ticks_q = cfg_data[LATCH_W-1:0];
          default: ;  // unmapped index, dropped
        endcase
      end
      if (in_valid && !in_stall)
        expand_request(in_op, in_red, in_green, in_blue, in_white, in_with_white);
    end
    outstanding <= phase_q.size();
    fail_count  <= errors;
  end

endmodule : ledser_checker

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the addressable LED bit serializer: directed
// pixel and latch requests under several timing settings, then random
// requests under four idle/stall modes. Checking lives in ledser_checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ledser_pkg::*;

  // index with no register behind it; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  // accept-to-first-phase latency plus the job load, rounded up
  localparam int SETTLE_CYCLES = 6;
  localparam int TAIL_CYCLES   = 16;
  localparam int RANDOM_PER_MODE = 108;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_op = OP_PIXEL;
  logic [7:0]            in_red = '0;
  logic [7:0]            in_green = '0;
  logic [7:0]            in_blue = '0;
  logic [7:0]            in_white = '0;
  logic                  in_with_white = 1'b0;
  logic                  out_stall = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  wire logic             in_stall;
  wire logic             out_valid;
  wire logic             out_level;
  wire logic [DUR_W-1:0] out_duration;
  wire logic             out_last;
  wire logic             cfg_ready;
  int                    outstanding;
  int                    fail_count;
  // percent chance per cycle of a sender gap / a receiver stall
  int                    idle_pct = 0;
  int                    stall_pct = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  addressable_led_bit_serializer_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_white     (in_white),
    .in_with_white(in_with_white),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_level    (out_level),
    .out_duration (out_duration),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  ledser_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_white     (in_white),
    .in_with_white(in_with_white),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_level    (out_level),
    .out_duration (out_duration),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .outstanding  (outstanding),
    .fail_count   (fail_count)
  );

  // Receiver back-pressure: a fresh coin every cycle, so stalls land on
  // every phase of a pixel run, including the last one and the latch.
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  // Watchdog. Worst honest run: ~450 requests x 64 phases, each phase held
  // by a long stall streak, comes to about 3.6 ms. Allow 8 ms.
  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Colors lean toward all-zeros / all-ones so both bit encodings show up in
  // long runs as well as mixed.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // One request transaction. Valid stays high after acceptance, so the next
  // transaction can follow back to back; a gap lowers it first and raises it
  // again only on a later edge.
  task automatic send_request(input logic op, input logic [7:0] red,
                              input logic [7:0] green, input logic [7:0] blue,
                              input logic [7:0] white, input logic with_white);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_red        <= red;
    in_green      <= green;
    in_blue       <= blue;
    in_white      <= white;
    in_with_white <= with_white;
    // stall is read as it stood at the edge, before any update from that edge
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  // Full timing set plus a stray write to the unmapped index, which the
  // following requests prove was dropped.
  task automatic program_timing(input logic [CFG_DATA_W-1:0] short_v,
                                input logic [CFG_DATA_W-1:0] long_v,
                                input logic [CFG_DATA_W-1:0] latch_v);
    write_reg(CFG_UNMAPPED, 16'($urandom));
    write_reg(CFG_SHORT_TICKS, short_v);
    write_reg(CFG_LONG_TICKS, long_v);
    write_reg(CFG_LATCH_TICKS, latch_v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait until every predicted phase has come out, then wait out
  // SETTLE_CYCLES more so registers only change while the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input int idle, input int stall);
    idle_pct  <= idle;
    stall_pct <= stall;
    @(posedge clk);
  endtask

  // A handful of requests that hit both encodings, both pixel sizes and the
  // latch, used under each directed timing setting.
  task automatic directed_burst();
    send_request(OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);  // white ignored
    send_request(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_request(OP_LATCH, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);  // colors ignored
    send_request(OP_PIXEL, 8'h80, 8'h01, 8'hAA, 8'h55, 1'b1);
    send_request(OP_LATCH, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
  endtask

  initial begin
    logic op;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: reset timing (50 / 100 / 6500), no idling ----
    directed_burst();
    send_request(OP_PIXEL, 8'h55, 8'hAA, 8'h0F, 8'hF0, 1'b0);
    send_request(OP_PIXEL, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1);
    drain();

    // zero short and latch registers must come out as one tick
    program_timing(16'd0, 16'd1023, 16'd0);
    directed_burst();
    drain();

    // extremes: short at its 10-bit maximum, long at one tick; latch at full 16 bits
    program_timing(16'd1023, 16'd1, 16'hFFFF);
    directed_burst();
    drain();

    // bits above the 10-bit fields are dropped: FFFF -> 1023, FC00 -> 0 -> 1
    program_timing(16'hFFFF, 16'hFC00, 16'h8000);
    directed_burst();
    drain();

    // ---- random: four idle/stall modes, fresh timing before each ----
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       set_mode(0, 0);
        1:       set_mode(82, 0);
        2:       set_mode(0, 82);
        default: set_mode(26, 26);
      endcase
      if ($urandom_range(1))
        program_timing(16'($urandom), 16'($urandom), 16'($urandom));
      else
        program_timing(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
                       16'($urandom_range(0, 300)));
      for (int n = 0; n < RANDOM_PER_MODE; n++) begin
        op = ($urandom_range(99) < 15) ? OP_LATCH : OP_PIXEL;
        send_request(op, pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                     1'($urandom));
      end
      drain();
    end

    set_mode(0, 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule : tb_top

@@ files.f @@
hw/rtl/ledser_pkg.sv
hw/rtl/ledser_front.sv
hw/rtl/ledser_queue.sv
hw/rtl/ledser_back.sv
hw/rtl/addressable_led_bit_serializer_top.sv
test/ledser_checker.sv
test/tb_top.sv
